FILE: rtl/core/ppsdw_pkg.sv
package ppsdw_pkg;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] capture_stamp;
      logic [63:0] location_bits;
      logic        location_valid;
      logic [31:0] time_seconds;
      logic        time_valid;
   } req_type;

   typedef struct packed {
      logic [15:0] compare_value;
      logic        compare_valid;
      logic        wave_level;
      logic        data_level;
      logic        data_valid;
      logic        pps_active;
      logic [31:0] measured_cycles;
   } rsp_type;

   localparam logic [1:0] ACT_PPS      = 2'd0;
   localparam logic [1:0] ACT_COMPARE  = 2'd1;
   localparam logic [1:0] ACT_OVERFLOW = 2'd2;

   localparam logic [1:0] REG_WAVE_ENABLE = 2'd0;
   localparam logic [1:0] REG_DATA_ENABLE = 2'd1;
   localparam logic [1:0] REG_WAVE_FREQ   = 2'd2;
   localparam logic [1:0] REG_BIT_REPEAT  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic event_go;     // run the event held in the request register
      logic div_start;    // start a calibration division
   } ctl_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic recal_pending;
   } ctl_sts_type;

endpackage

FILE: rtl/core/ppsdw_divider.sv
// Restoring divider: one quotient bit per cycle.
module ppsdw_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [15:0] quotient,
   output logic [15:0] remainder
);
   logic [31:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[15:0], quot_ff[31]};
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = 6'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // Shift in the next dividend bit and subtract where it fits.
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = trial - {1'b0, div_ff};
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[30:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quot_ff[15:0];
   assign remainder = rem_ff[15:0];
endmodule

FILE: rtl/core/ppsdw_datapath.sv
module ppsdw_datapath #(
   parameter int NOMINAL_CLOCK = 16000000,
   parameter int PPS_TIMEOUT   = 32000000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ppsdw_pkg::req_type    req_data,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [14:0]           csr_wdata,
   input  ppsdw_pkg::ctl_cmd_type cmd,
   output ppsdw_pkg::ctl_sts_type sts,
   output ppsdw_pkg::rsp_type    rsp_result
);
   import ppsdw_pkg::*;

   logic        wave_en_ff, data_en_ff;
   logic [14:0] freq_ff;
   logic [7:0]  repeat_cfg_ff;

   logic        pps_seen_ff, pps_seen_in;
   logic        armed_ff, armed_in;
   logic [15:0] ovf_ff, ovf_in;
   logic [15:0] stamp_ff, stamp_in;
   logic [31:0] cps_ff, cps_in;
   logic [15:0] half_ff, half_in;
   logic [15:0] hrem_ff, hrem_in;
   logic        wave_ff, wave_in;
   logic [15:0] hcount_ff, hcount_in;
   logic [15:0] step_ff, step_in;
   logic [15:0] csum_ff, csum_in;
   logic [63:0] shift_ff, shift_in;
   logic [6:0]  bits_ff, bits_in;
   logic [2:0]  stage_ff, stage_in;
   logic [7:0]  rcount_ff, rcount_in;
   logic        fdone_ff, fdone_in;
   logic [63:0] loc_ff, loc_in;
   logic        loc_ok_ff, loc_ok_in;
   logic [31:0] sec_ff, sec_in;
   logic        sec_ok_ff, sec_ok_in;
   logic        recal_ff, recal_in;
   rsp_type     rsp_ff, rsp_in;

   logic [15:0] two_f;
   logic [15:0] proj, step_next, hcount_next;
   logic [31:0] elapsed, ovf_elapsed;
   logic [15:0] ovf_next;
   logic        div_busy, div_done;
   logic [15:0] div_q, div_r;
   logic        wave_go, wave_go_pps;
   logic [15:0] cmp_out;
   logic        dat_out, dat_ok;
   logic [63:0] sw;
   logic [6:0]  bl;
   logic [2:0]  fs;
   logic [15:0] hc_base, st_base, cs_base;

   assign two_f = (freq_ff == 15'd0) ? 16'd2 : {freq_ff, 1'b0};

   ppsdw_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cps_ff),
      .divisor  (two_f),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   assign elapsed     = {ovf_ff, 16'd0} + {16'd0, req_data.capture_stamp} - {16'd0, stamp_ff};
   assign ovf_next    = ovf_ff + 16'd1;
   assign ovf_elapsed = {ovf_next, 16'd0} - {16'd0, stamp_ff};

   // Event logic; the compare product is a 16x16 multiply, and the correction projection is a second one.
   always_comb begin
      pps_seen_in = pps_seen_ff;  armed_in = armed_ff;   ovf_in = ovf_ff;
      stamp_in = stamp_ff;        cps_in = cps_ff;       half_in = half_ff;
      hrem_in = hrem_ff;          wave_in = wave_ff;     hcount_in = hcount_ff;
      step_in = step_ff;          csum_in = csum_ff;     shift_in = shift_ff;
      bits_in = bits_ff;          stage_in = stage_ff;   rcount_in = rcount_ff;
      fdone_in = fdone_ff;        loc_in = loc_ff;       loc_ok_in = loc_ok_ff;
      sec_in = sec_ff;            sec_ok_in = sec_ok_ff; recal_in = recal_ff;
      rsp_in = rsp_ff;
      wave_go = 1'b0; wave_go_pps = 1'b0;
      cmp_out = '0; dat_out = 1'b0; dat_ok = 1'b0;
      proj = '0; step_next = '0; hcount_next = '0;
      sw = shift_ff; bl = bits_ff; fs = stage_ff;
      hc_base = hcount_ff; st_base = step_ff; cs_base = csum_ff;

      if (div_done) begin
         half_in  = div_q;
         hrem_in  = div_r;
         recal_in = 1'b0;
      end

      if (cmd.event_go) begin
         case (req_data.action)
            ACT_PPS: begin
               if (armed_ff) begin
                  cps_in   = elapsed;
                  recal_in = 1'b1;
               end
               armed_in  = 1'b1;
               stamp_in  = req_data.capture_stamp;
               loc_in    = req_data.location_bits;
               loc_ok_in = req_data.location_valid;
               sec_in    = req_data.time_seconds;
               sec_ok_in = req_data.time_valid;
               fs = 3'd0; bl = 7'd0; rcount_in = 8'd0;
               stage_in = 3'd0; bits_in = 7'd0;
               if (wave_en_ff && pps_seen_ff) begin
                  wave_go_pps = 1'b1;
                  hc_base = '0; st_base = '0; cs_base = '0;
                  wave_in = 1'b0; fdone_in = 1'b0;
               end
               ovf_in      = '0;
               pps_seen_in = 1'b1;
            end
            ACT_COMPARE: wave_go = wave_en_ff;
            ACT_OVERFLOW: begin
               ovf_in = ovf_next;
               if (ovf_elapsed > PPS_TIMEOUT[31:0]) begin
                  ovf_in = '0; armed_in = 1'b0; pps_seen_in = 1'b0;
               end
            end
            default: ;
         endcase

         if (wave_go || wave_go_pps) begin
            wave_in = wave_go_pps ? 1'b1 : ~wave_ff;
            proj = cs_base + st_base * (two_f - hc_base);
            if (proj < hrem_ff)      step_next = st_base + 16'd1;
            else if (proj > hrem_ff) step_next = st_base - 16'd1;
            else                     step_next = st_base;
            hcount_next = hc_base + 16'd1;
            step_in   = step_next;
            hcount_in = hcount_next;
            csum_in   = cs_base + step_next;
            cmp_out   = half_ff * hcount_next + step_next;
            // Serial data bit on this half-wave.
            if (data_en_ff && !(wave_go_pps ? 1'b0 : fdone_ff)) begin
               if (!wave_in) begin
                  dat_ok = 1'b1;
               end else if (bl == 7'd0 && fs >= 3'd4) begin
                  fdone_in = 1'b1;
               end else begin
                  if (bl == 7'd0) begin
                     case (fs)
                        3'd1: begin
                           sw = loc_ok_ff ? loc_ff : 64'd0; bl = 7'd64;
                        end
                        3'd2: begin
                           sw = sec_ok_ff ? {32'd0, sec_ff} : 64'd0; bl = 7'd32;
                        end
                        default: begin
                           sw = 64'd1; bl = 7'd1;
                        end
                     endcase
                     fs = fs + 3'd1;
                  end
                  dat_out = sw[0];
                  dat_ok  = 1'b1;
                  if (rcount_in == repeat_cfg_ff - 8'd1) begin
                     sw = {1'b0, sw[63:1]};
                     bl = bl - 7'd1;
                     rcount_in = 8'd0;
                  end else begin
                     rcount_in = rcount_in + 8'd1;
                  end
                  shift_in = sw; bits_in = bl; stage_in = fs;
               end
            end
         end

         rsp_in.compare_value   = cmp_out;
         rsp_in.compare_valid   = wave_go || wave_go_pps;
         rsp_in.wave_level      = wave_in;
         rsp_in.data_level      = dat_out;
         rsp_in.data_valid      = dat_ok;
         rsp_in.pps_active      = pps_seen_in;
         rsp_in.measured_cycles = cps_in;
      end

      if (csr_write && csr_index == REG_WAVE_FREQ) recal_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      shift_ff <= shift_in;
      loc_ff   <= loc_in;
      sec_ff   <= sec_in;
      if (reset) begin
         wave_en_ff <= 1'b0; data_en_ff <= 1'b0;
         freq_ff <= 15'd1;   repeat_cfg_ff <= 8'd1;
         pps_seen_ff <= 1'b0; armed_ff <= 1'b0; ovf_ff <= '0; stamp_ff <= '0;
         cps_ff <= NOMINAL_CLOCK[31:0]; half_ff <= '0; hrem_ff <= '0;
         wave_ff <= 1'b0; hcount_ff <= '0; step_ff <= '0; csum_ff <= '0;
         bits_ff <= '0; stage_ff <= 3'd4; rcount_ff <= '0; fdone_ff <= 1'b1;
         loc_ok_ff <= 1'b0; sec_ok_ff <= 1'b0; recal_ff <= 1'b0;
      end else begin
         pps_seen_ff <= pps_seen_in; armed_ff <= armed_in; ovf_ff <= ovf_in;
         stamp_ff <= stamp_in; cps_ff <= cps_in; half_ff <= half_in;
         hrem_ff <= hrem_in; wave_ff <= wave_in; hcount_ff <= hcount_in;
         step_ff <= step_in; csum_ff <= csum_in; bits_ff <= bits_in;
         stage_ff <= stage_in; rcount_ff <= rcount_in; fdone_ff <= fdone_in;
         loc_ok_ff <= loc_ok_in; sec_ok_ff <= sec_ok_in; recal_ff <= recal_in;
         // Register writes.
         if (csr_write) begin
            case (csr_index)
               REG_WAVE_ENABLE: wave_en_ff    <= csr_wdata[0];
               REG_DATA_ENABLE: data_en_ff    <= csr_wdata[0];
               REG_WAVE_FREQ:   freq_ff       <= csr_wdata;
               REG_BIT_REPEAT:  repeat_cfg_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   assign sts.div_busy      = div_busy;
   assign sts.recal_pending = recal_ff;
   assign rsp_result        = rsp_ff;

`ifndef ASSERT_OFF
   // A division is never restarted while one is still running.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy) else $error("division restarted while busy");
   // The frame stage never runs past the end of the frame.
   a_stage: assert property (@(posedge clock) disable iff (reset)
      stage_ff <= 3'd4) else $error("frame stage out of range");
   // Each bit of the frame comes from a stage that has already advanced.
   a_bits: assert property (@(posedge clock) disable iff (reset)
      (bits_ff != 7'd0) |-> (stage_ff != 3'd0)) else $error("bits left without a stage");
`endif
endmodule

FILE: rtl/core/ppsdw_control.sv
module ppsdw_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ppsdw_pkg::ctl_sts_type sts,
   output ppsdw_pkg::ctl_cmd_type cmd
);
   import ppsdw_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       out_ff, out_in;
   logic       accept;

   // Accept when idle, the result register is free and no calibration is pending or running.
   assign req_ready = (state_ff == ST_IDLE) && !out_ff && !sts.recal_pending && !sts.div_busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      out_in        = out_ff;
      cmd.event_go  = 1'b0;
      cmd.div_start = 1'b0;
      if (out_ff && rsp_ready) out_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
            end else if (sts.recal_pending && !sts.div_busy) begin
               cmd.div_start = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_RUN: begin
            cmd.event_go = 1'b1;
            out_in   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WAIT: begin
            if (!sts.div_busy && !cmd.div_start) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
      end
   end

   assign rsp_valid = out_ff;

`ifndef ASSERT_OFF
   // An event never runs while a calibration division is running.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.event_go |-> !sts.div_busy) else $error("event during division");
   // An accepted transaction runs in the next cycle.
   a_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> cmd.event_go) else $error("accepted transaction not run");
   // A result is produced only for a run event.
   a_out: assert property (@(posedge clock) disable iff (reset)
      $rose(out_ff) |-> $past(cmd.event_go)) else $error("spurious result");
`endif
endmodule

FILE: rtl/core/pps_disciplined_wave_generator.sv
// PPS-disciplined square wave and data generator. Each transaction carries one
// timer event (PPS capture, compare match or overflow) and returns one result.
// An event is held in the request register, run, and its result held until it
// is taken; a PPS capture that recalibrates, or a write to the frequency
// register, then runs a bit-serial divider to completion before the next
// transaction is accepted.
module pps_disciplined_wave_generator #(
   parameter int NOMINAL_CLOCK = 16000000,
   parameter int PPS_TIMEOUT   = 32000000
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ppsdw_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ppsdw_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_wdata
);
   import ppsdw_pkg::*;

   ctl_cmd_type    cmd;
   ctl_sts_type    sts;
   req_type        req_ff;

   // Hold the accepted request for the event cycle.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
   end

   ppsdw_control u_ctl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   ppsdw_datapath #(
      .NOMINAL_CLOCK(NOMINAL_CLOCK),
      .PPS_TIMEOUT  (PPS_TIMEOUT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_ff),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_result(rsp_data)
   );
endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import ppsdw_pkg::*;

   localparam int NOMINAL_HZ  = 16000000;
   localparam int TIMEOUT_CYC = 32000000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // Cycles left after the last result or a register write for a calibration division to finish.
   localparam int DIV_SETTLE = 50;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [1:0]  csr_index = REG_WAVE_ENABLE;
   logic [14:0] csr_wdata = '0;

   pps_disciplined_wave_generator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the generator's configuration and state.
   logic        cfg_wave_en, cfg_data_en;
   logic [14:0] cfg_freq;
   logic [7:0]  cfg_repeat;
   logic        sh_pps_seen, sh_cal_armed, sh_wave, sh_frame_done;
   logic [15:0] sh_ovf_count, sh_pps_stamp, sh_half_period, sh_half_rem;
   logic [15:0] sh_half_count, sh_step_corr, sh_corr_sum;
   logic [31:0] sh_cycles, sh_lat_seconds;
   logic [63:0] sh_shift, sh_lat_location;
   logic [6:0]  sh_bits_left;
   logic [2:0]  sh_frame_stage;
   logic [7:0]  sh_repeat_count;
   logic        sh_lat_location_ok, sh_lat_seconds_ok;

   rsp_type pending_results[$];
   int      fail_count = 0;
   int      items_sent = 0;
   int      results_seen = 0;
   bit      idling_on = 1'b1;
   int      rsp_stall_left = 0;

   function automatic logic [31:0] double_freq();
      logic [31:0] f;
      f = (cfg_freq == 15'd0) ? 32'd1 : {17'd0, cfg_freq};
      return f * 2;
   endfunction

   function automatic void recompute_half_period();
      logic [31:0] d;
      d = double_freq();
      sh_half_period = 16'((sh_cycles / d) & 32'hFFFF);
      sh_half_rem    = 16'((sh_cycles % d) & 32'hFFFF);
   endfunction

   function automatic void shadow_reset();
      cfg_wave_en = 0; cfg_data_en = 0; cfg_freq = 15'd1; cfg_repeat = 8'd1;
      sh_pps_seen = 0; sh_cal_armed = 0; sh_ovf_count = 0; sh_pps_stamp = 0;
      sh_cycles = NOMINAL_HZ; sh_half_period = 0; sh_half_rem = 0;
      sh_wave = 0; sh_half_count = 0; sh_step_corr = 0; sh_corr_sum = 0;
      sh_shift = 0; sh_bits_left = 0; sh_frame_stage = 3'd4; sh_repeat_count = 0;
      sh_frame_done = 1; sh_lat_location = 0; sh_lat_location_ok = 0;
      sh_lat_seconds = 0; sh_lat_seconds_ok = 0;
   endfunction

   // One half-wave: toggle, advance the compare point and drive the data line.
   function automatic void half_wave(ref rsp_type r);
      logic [31:0] proj;
      if (!cfg_wave_en) return;
      sh_wave = ~sh_wave;
      proj = (32'(sh_corr_sum) + 32'(sh_step_corr) * (double_freq() - 32'(sh_half_count)))
             & 32'hFFFF;
      if (proj < 32'(sh_half_rem)) sh_step_corr = sh_step_corr + 16'd1;
      else if (proj > 32'(sh_half_rem)) sh_step_corr = sh_step_corr - 16'd1;
      sh_half_count = sh_half_count + 16'd1;
      sh_corr_sum = sh_corr_sum + sh_step_corr;
      r.compare_value = 16'(sh_half_period * sh_half_count + sh_step_corr);
      r.compare_valid = 1'b1;
      if (!(cfg_data_en && !sh_frame_done)) return;
      if (!sh_wave) begin
         r.data_level = 1'b0;
         r.data_valid = 1'b1;
         return;
      end
      if (sh_bits_left == 0) begin
         if (sh_frame_stage >= 3'd4) begin
            sh_frame_done = 1'b1;
            return;
         end
         if (sh_frame_stage == 3'd1) begin
            sh_shift = sh_lat_location_ok ? sh_lat_location : 64'd0;
            sh_bits_left = 7'd64;
         end else if (sh_frame_stage == 3'd2) begin
            sh_shift = sh_lat_seconds_ok ? {32'd0, sh_lat_seconds} : 64'd0;
            sh_bits_left = 7'd32;
         end else begin
            sh_shift = 64'd1;
            sh_bits_left = 7'd1;
         end
         sh_frame_stage = sh_frame_stage + 3'd1;
      end
      r.data_level = sh_shift[0];
      r.data_valid = 1'b1;
      if (sh_repeat_count == cfg_repeat - 8'd1) begin
         sh_shift = sh_shift >> 1;
         sh_bits_left = sh_bits_left - 7'd1;
         sh_repeat_count = 0;
      end else begin
         sh_repeat_count = sh_repeat_count + 8'd1;
      end
   endfunction

   function automatic rsp_type predict_event(req_type q);
      rsp_type r;
      logic [31:0] elapsed;
      logic recal;
      r = '0;
      case (q.action)
         ACT_PPS: begin
            elapsed = {sh_ovf_count, 16'd0} + 32'(q.capture_stamp) - 32'(sh_pps_stamp);
            recal = sh_cal_armed;
            if (recal) sh_cycles = elapsed;
            sh_cal_armed = 1'b1;
            sh_pps_stamp = q.capture_stamp;
            sh_lat_location = q.location_bits;
            sh_lat_location_ok = q.location_valid;
            sh_lat_seconds = q.time_seconds;
            sh_lat_seconds_ok = q.time_valid;
            sh_frame_stage = 0; sh_bits_left = 0; sh_repeat_count = 0;
            if (cfg_wave_en && sh_pps_seen) begin
               sh_wave = 0; sh_half_count = 0; sh_step_corr = 0; sh_corr_sum = 0;
               sh_frame_done = 0;
               half_wave(r);
            end
            sh_ovf_count = 0;
            sh_pps_seen = 1'b1;
            if (recal) recompute_half_period();
         end
         ACT_COMPARE: half_wave(r);
         ACT_OVERFLOW: begin
            sh_ovf_count = sh_ovf_count + 16'd1;
            if ({sh_ovf_count, 16'd0} - 32'(sh_pps_stamp) > 32'(TIMEOUT_CYC)) begin
               sh_ovf_count = 0; sh_cal_armed = 0; sh_pps_seen = 0;
            end
         end
         default: ;
      endcase
      r.wave_level = sh_wave;
      r.pps_active = sh_pps_seen;
      r.measured_cycles = sh_cycles;
      return r;
   endfunction

   // Result side: random back-pressure and comparison against the oldest prediction.
   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with no prediction waiting");
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            results_seen++;
            check_field("compare_value", e.compare_value, rsp_data.compare_value);
            check_field("compare_valid", e.compare_valid, rsp_data.compare_valid);
            check_field("wave_level", e.wave_level, rsp_data.wave_level);
            check_field("data_level", e.data_level, rsp_data.data_level);
            check_field("data_valid", e.data_valid, rsp_data.data_valid);
            check_field("pps_active", e.pps_active, rsp_data.pps_active);
            check_field("measured_cycles", e.measured_cycles, rsp_data.measured_cycles);
         end
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready <= (rsp_stall_left == 1);
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left <= $urandom_range(1, 17);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Send one event transaction and record its predicted result.
   task automatic send_event(req_type q);
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_event(q));
      items_sent++;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   function automatic req_type make_event(logic [1:0] act);
      req_type q;
      q.action = act;
      q.capture_stamp = 16'($urandom);
      q.location_bits = {$urandom, $urandom};
      q.location_valid = 1'($urandom);
      q.time_seconds = $urandom;
      q.time_valid = 1'($urandom);
      return q;
   endfunction

   // Let every result arrive, then give a pending division time to finish.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DIV_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [14:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_WAVE_ENABLE: cfg_wave_en = val[0];
         REG_DATA_ENABLE: cfg_data_en = val[0];
         REG_WAVE_FREQ: begin
            cfg_freq = val;
            recompute_half_period();
         end
         default: cfg_repeat = val[7:0];
      endcase
      repeat (DIV_SETTLE) @(posedge clock);
   endtask

   task automatic set_config(bit wen, bit den, logic [14:0] freq, logic [7:0] rep);
      drain();
      write_reg(REG_WAVE_ENABLE, {14'd0, wen});
      write_reg(REG_DATA_ENABLE, {14'd0, den});
      write_reg(REG_WAVE_FREQ, freq);
      write_reg(REG_BIT_REPEAT, {7'd0, rep});
   endtask

   // Field extremes, every action, unused action, zero frequency and zero repeat.
   task automatic test_directed();
      req_type q;
      set_config(1, 1, 15'd32767, 8'd1);
      q = '0; q.action = ACT_UNUSED; send_event(q);
      q = '0; q.action = ACT_COMPARE; send_event(q);
      q = '0; q.action = ACT_OVERFLOW; send_event(q);
      q = '1; q.action = ACT_PPS; q.capture_stamp = 16'd0; send_event(q);
      q = '1; q.action = ACT_PPS; send_event(q);
      q = '0; q.action = ACT_PPS; send_event(q);
      repeat (6) send_event(make_event(ACT_COMPARE));
      send_event(make_event(ACT_OVERFLOW));
      q = '1; q.action = ACT_PPS; send_event(q);
      repeat (4) send_event(make_event(ACT_COMPARE));
      set_config(1, 1, 15'd0, 8'd0);
      send_event(make_event(ACT_PPS));
      repeat (5) send_event(make_event(ACT_COMPARE));
   endtask

   // A whole data frame to its end bit, while overflows with no PPS run on
   // until the timeout drops the PPS lock.
   task automatic test_timeout();
      set_config(1, 1, 15'd1000, 8'd1);
      send_event(make_event(ACT_PPS));
      send_event(make_event(ACT_PPS));
      for (int i = 0; i < 490; i++) begin
         send_event(make_event(ACT_OVERFLOW));
         if (i < 200) send_event(make_event(ACT_COMPARE));
      end
      send_event(make_event(ACT_PPS));
      send_event(make_event(ACT_COMPARE));
   endtask

   // Mostly well-formed seconds: a PPS and a run of half-waves, with some noise.
   task automatic run_seconds(int count);
      int n, k, sel;
      n = 0;
      while (n < count) begin
         send_event(make_event(ACT_PPS));
         n++;
         k = $urandom_range(0, 24);
         if (k > count - n) k = count - n;
         repeat (k) begin
            sel = $urandom_range(0, 39);
            if (sel == 0) send_event(make_event(ACT_UNUSED));
            else if (sel < 3) send_event(make_event(ACT_OVERFLOW));
            else if (sel == 3) send_event(make_event(ACT_PPS));
            else send_event(make_event(ACT_COMPARE));
            n++;
         end
      end
   endtask

   task automatic test_random();
      set_config(1, 1, 15'($urandom_range(1, 32767)), 8'd1);
      run_seconds(12);
      set_config(1, 1, 15'($urandom_range(1, 200)), 8'($urandom_range(1, 3)));
      run_seconds(12);
      set_config(0, 1, 15'($urandom_range(1, 32767)), 8'($urandom_range(1, 255)));
      run_seconds(8);
      set_config(1, 1, 15'd1, 8'd255);
      run_seconds(10);
      set_config(1, 0, 15'($urandom), 8'($urandom));
      run_seconds(8);
   endtask

   task automatic test_no_idling();
      set_config(1, 1, 15'($urandom_range(1, 32767)), 8'($urandom_range(1, 2)));
      idling_on = 1'b0;
      run_seconds(30);
   endtask

   initial begin
      shadow_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_timeout();
      test_random();
      test_no_idling();
      drain();
      $display("Sent %0d event transactions and checked %0d results", items_sent,
               results_seen);
      $display("across several wave, data, frequency and bit-repeat settings.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ppsdw_pkg.sv
rtl/core/ppsdw_divider.sv
rtl/core/ppsdw_datapath.sv
rtl/core/ppsdw_control.sv
rtl/core/pps_disciplined_wave_generator.sv
verif/tb.sv
